// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker in lfe_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared constants for the line extension unit: register and output widths,
// register indexes and reset sizes.
// ----------------------------------------------------------------------------
package lfe_pkg;

  // Frame size registers
  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [REG_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [REG_W-1:0] WIDTH_RST  = 13'd640;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;

  // Output coordinate format
  localparam int OUT_W = 24;

endpackage

// ===== hw/rtl/lfe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfe_div
// Pipelined restoring divider: two dividends over one shared divisor,
// STEP_BITS quotient bits per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
module lfe_div #(
  parameter int DVD_W     = 34,
  parameter int DVS_W     = 13,
  parameter int SB_W      = 16,
  parameter int STEP_BITS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DVD_W-1:0] in_dvd_a,
  input  logic [DVD_W-1:0] in_dvd_b,
  input  logic [DVS_W-1:0] in_dvs,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [DVD_W-1:0] out_quo_a,
  output logic [DVD_W-1:0] out_quo_b,
  output logic [SB_W-1:0]  out_sb
);

  localparam int NST = (DVD_W + STEP_BITS - 1) / STEP_BITS;

  // Per-stage state: work word holds remaining dividend bits on top,
  // quotient bits shift in at the bottom.
  logic [DVD_W-1:0] wa_r  [NST];
  logic [DVD_W-1:0] wb_r  [NST];
  logic [DVS_W-1:0] ra_r  [NST];
  logic [DVS_W-1:0] rb_r  [NST];
  logic [DVS_W-1:0] dvs_r [NST];
  logic [SB_W-1:0]  sb_r  [NST];
  logic [NST-1:0]   v_r;

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [DVD_W-1:0] wa_src, wb_src;
    logic [DVS_W-1:0] ra_src, rb_src, dvs_src;
    logic [SB_W-1:0]  sb_src;
    logic             v_src;
    logic [DVD_W-1:0] wa_nxt, wb_nxt;
    logic [DVS_W-1:0] ra_nxt, rb_nxt;

    // Stage source
    if (s == 0) begin : g_first
      assign wa_src  = in_dvd_a;
      assign wb_src  = in_dvd_b;
      assign ra_src  = '0;
      assign rb_src  = '0;
      assign dvs_src = in_dvs;
      assign sb_src  = in_sb;
      assign v_src   = in_valid;
    end else begin : g_next
      assign wa_src  = wa_r[s-1];
      assign wb_src  = wb_r[s-1];
      assign ra_src  = ra_r[s-1];
      assign rb_src  = rb_r[s-1];
      assign dvs_src = dvs_r[s-1];
      assign sb_src  = sb_r[s-1];
      assign v_src   = v_r[s-1];
    end

    // Shift-subtract steps of this stage
    always_comb begin
      logic [DVS_W:0] ta, tb;
      logic [DVD_W-1:0] wa, wb;
      logic [DVS_W-1:0] ra, rb;
      wa = wa_src;
      wb = wb_src;
      ra = ra_src;
      rb = rb_src;
      ta = '0;
      tb = '0;
      for (int k = 0; k < STEP_BITS; k++) begin
        if (s * STEP_BITS + k < DVD_W) begin
          ta = {ra, wa[DVD_W-1]};
          tb = {rb, wb[DVD_W-1]};
          wa = wa << 1;
          wb = wb << 1;
          if (ta >= {1'b0, dvs_src}) begin
            ta    = ta - {1'b0, dvs_src};
            wa[0] = 1'b1;
          end
          if (tb >= {1'b0, dvs_src}) begin
            tb    = tb - {1'b0, dvs_src};
            wb[0] = 1'b1;
          end
          ra = ta[DVS_W-1:0];
          rb = tb[DVS_W-1:0];
        end
      end
      wa_nxt = wa;
      wb_nxt = wb;
      ra_nxt = ra;
      rb_nxt = rb;
    end

    // Stage registers
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        wa_r[s]  <= wa_nxt;
        wb_r[s]  <= wb_nxt;
        ra_r[s]  <= ra_nxt;
        rb_r[s]  <= rb_nxt;
        dvs_r[s] <= dvs_src;
        sb_r[s]  <= sb_src;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_quo_a = wa_r[NST-1];
  assign out_quo_b = wb_r[NST-1];
  assign out_sb    = sb_r[NST-1];

endmodule

// ===== hw/rtl/line_extend_to_frame_edges_unit.sv =====
`timescale 1ns / 1ps
// Extends a segment to the frame borders, one segment per clock while
// out_stall does not hold the pipeline. The pipeline has three front stages,
// ceil(QW/4) divider stages resolving four quotient bits each, and the output
// register, where QW = COORD_BITS + max(COORD_BITS, 13) + FRAC_BITS + 5 is the
// dividend width (nine divider stages at the defaults). The whole pipeline
// holds while a result waits on out_stall, so in_stall follows out_stall while
// the output register is full.
// ----------------------------------------------------------------------------
// line_extend_to_frame_edges_unit
// Border intersection of a line segment, signed fixed point results with
// rounding to nearest (ties away from zero) and saturation.
// ----------------------------------------------------------------------------
module line_extend_to_frame_edges_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lfe_pkg::REG_W-1:0]          cfg_data,
  // segment input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [COORD_BITS-1:0]              in_x_start,
  input  logic [COORD_BITS-1:0]              in_y_start,
  input  logic [COORD_BITS-1:0]              in_x_end,
  input  logic [COORD_BITS-1:0]              in_y_end,
  // result output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lfe_pkg::OUT_W-1:0]   out_first_x,
  output logic signed [lfe_pkg::OUT_W-1:0]   out_first_y,
  output logic signed [lfe_pkg::OUT_W-1:0]   out_second_x,
  output logic signed [lfe_pkg::OUT_W-1:0]   out_second_y,
  output logic                               out_cut_left_right,
  output logic                               out_degenerate,
  output logic                               out_saturated
);

  localparam int C     = COORD_BITS;
  localparam int RW    = lfe_pkg::REG_W;
  localparam int OW    = lfe_pkg::OUT_W;
  localparam int DW    = ((C > RW) ? C : RW) + 1;
  localparam int NUM_W = C + DW + 2;
  localparam int QW    = NUM_W + FRAC_BITS + 2;
  localparam int SB_W  = C + 4;

  // Frame size registers
  logic [RW-1:0] frame_height_r, frame_width_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_height_r <= lfe_pkg::HEIGHT_RST;
      frame_width_r  <= lfe_pkg::WIDTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lfe_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        lfe_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: move unless the output holds a stalled result
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Stage 1: differences, direction fix, classification
  logic                 v1_r, degen1_r, horiz1_r;
  logic [C-1:0]         x1_r, y1_r, dy1_r;
  logic signed [C:0]    dx1_r;
  logic signed [DW-1:0] hy1_r;
  logic signed [C:0]    dx_raw, dy_raw, dx_nxt;
  logic [C-1:0]         dy_nxt;

  assign dx_raw = $signed({1'b0, in_x_end}) - $signed({1'b0, in_x_start});
  assign dy_raw = $signed({1'b0, in_y_end}) - $signed({1'b0, in_y_start});
  assign dx_nxt = dy_raw[C] ? -dx_raw : dx_raw;
  assign dy_nxt = dy_raw[C] ? C'(-dy_raw) : dy_raw[C-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r     <= in_x_start;
      y1_r     <= in_y_start;
      dx1_r    <= dx_nxt;
      dy1_r    <= dy_nxt;
      hy1_r    <= DW'($signed({1'b0, frame_height_r})) - DW'($signed({1'b0, in_y_start}));
      degen1_r <= (in_x_start == in_x_end) && (in_y_start == in_y_end);
      horiz1_r <= (in_y_start == in_y_end);
    end
  end

  // Stage 2: cross products
  logic                    v2_r, degen2_r, horiz2_r;
  logic [C-1:0]            y2_r, dy2_r;
  logic [2*C-1:0]          p1_r;
  logic signed [2*C+1:0]   p2_r;
  logic signed [DW+C:0]    p3_r;
  logic [2*C-1:0]          p1_nxt;
  logic signed [2*C+1:0]   p2_nxt;
  logic signed [DW+C:0]    p3_nxt;

  assign p1_nxt = x1_r * dy1_r;
  assign p2_nxt = $signed({1'b0, y1_r}) * dx1_r;
  assign p3_nxt = hy1_r * dx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= p1_nxt;
      p2_r     <= p2_nxt;
      p3_r     <= p3_nxt;
      y2_r     <= y1_r;
      dy2_r    <= dy1_r;
      degen2_r <= degen1_r;
      horiz2_r <= horiz1_r;
    end
  end

  // Stage 3: numerators, magnitude, rounding offset
  logic signed [NUM_W-1:0] e1, e2, e3, n1, n2;
  logic [NUM_W-1:0]        m1, m2;
  logic                    v3_r;
  logic [QW-1:0]           dvd_a_r, dvd_b_r;
  logic [C:0]              dvs_r;
  logic [SB_W-1:0]         sb3_r;

  assign e1 = NUM_W'($signed({1'b0, p1_r}));
  assign e2 = NUM_W'(p2_r);
  assign e3 = NUM_W'(p3_r);
  assign n1 = e1 - e2;
  assign n2 = e1 + e3;
  assign m1 = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
  assign m2 = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  // (2*|n|*2^F + d) / (2*d) rounds half away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      dvd_a_r <= (QW'(m1) << (FRAC_BITS + 1)) + QW'(dy2_r);
      dvd_b_r <= (QW'(m2) << (FRAC_BITS + 1)) + QW'(dy2_r);
      dvs_r   <= {dy2_r, 1'b0};
      sb3_r   <= {n1[NUM_W-1], n2[NUM_W-1], degen2_r, horiz2_r, y2_r};
    end
  end

  // Divider pipeline
  logic            dv_valid;
  logic [QW-1:0]   q_a, q_b;
  logic [SB_W-1:0] dv_sb;

  lfe_div #(
    .DVD_W     (QW),
    .DVS_W     (C + 1),
    .SB_W      (SB_W),
    .STEP_BITS (4)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_dvd_a  (dvd_a_r),
    .in_dvd_b  (dvd_b_r),
    .in_dvs    (dvs_r),
    .in_sb     (sb3_r),
    .out_valid (dv_valid),
    .out_quo_a (q_a),
    .out_quo_b (q_b),
    .out_sb    (dv_sb)
  );

  // Saturate sign and magnitude to the output range; MSB is the clip flag
  function automatic logic [OW:0] clip_f(input logic neg, input logic [QW-1:0] mag);
    logic [OW:0] res;
    if (!neg) begin
      if (mag > QW'({1'b0, {(OW-1){1'b1}}})) begin
        res = {1'b1, 1'b0, {(OW-1){1'b1}}};
      end else begin
        res = {1'b0, mag[OW-1:0]};
      end
    end else begin
      if (mag > QW'({1'b1, {(OW-1){1'b0}}})) begin
        res = {1'b1, 1'b1, {(OW-1){1'b0}}};
      end else begin
        res = {1'b0, OW'(-mag)};
      end
    end
    return res;
  endfunction

  // Output stage: select by segment class, clip, register
  logic          s_neg_a, s_neg_b, s_degen, s_horiz;
  logic [C-1:0]  s_y1;
  logic [OW:0]   c_fx, c_fy, c_sx, c_sy;
  logic [OW:0]   c_yl, c_w, c_h, c_qa, c_qb;
  logic [OW-1:0] fx_nxt, fy_nxt, sx_nxt, sy_nxt;
  logic          sat_nxt;

  assign {s_neg_a, s_neg_b, s_degen, s_horiz, s_y1} = dv_sb;

  assign c_yl = clip_f(1'b0, QW'(s_y1) << FRAC_BITS);
  assign c_w  = clip_f(1'b0, QW'(frame_width_r) << FRAC_BITS);
  assign c_h  = clip_f(1'b0, QW'(frame_height_r) << FRAC_BITS);
  assign c_qa = clip_f(s_neg_a, q_a);
  assign c_qb = clip_f(s_neg_b, q_b);

  always_comb begin
    if (s_degen) begin
      c_fx = '0;
      c_fy = '0;
      c_sx = '0;
      c_sy = '0;
    end else if (s_horiz) begin
      c_fx = '0;
      c_fy = c_yl;
      c_sx = c_w;
      c_sy = c_yl;
    end else begin
      c_fx = c_qa;
      c_fy = '0;
      c_sx = c_qb;
      c_sy = c_h;
    end
    fx_nxt  = c_fx[OW-1:0];
    fy_nxt  = c_fy[OW-1:0];
    sx_nxt  = c_sx[OW-1:0];
    sy_nxt  = c_sy[OW-1:0];
    sat_nxt = c_fx[OW] | c_fy[OW] | c_sx[OW] | c_sy[OW];
  end

  logic [OW-1:0] fx_r, fy_r, sx_r, sy_r;
  logic          horiz_r, degen_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_r    <= fx_nxt;
      fy_r    <= fy_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      horiz_r <= s_horiz & ~s_degen;
      degen_r <= s_degen;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_x        = $signed(fx_r);
  assign out_first_y        = $signed(fy_r);
  assign out_second_x       = $signed(sx_r);
  assign out_second_y       = $signed(sy_r);
  assign out_cut_left_right = horiz_r;
  assign out_degenerate     = degen_r;
  assign out_saturated      = sat_r;

endmodule

// ===== hw/rtl/lfe_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfe_chk
// Port-level checks on the result channel of the line extension unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfe_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [lfe_pkg::OUT_W-1:0] out_first_x,
  input logic signed [lfe_pkg::OUT_W-1:0] out_first_y,
  input logic signed [lfe_pkg::OUT_W-1:0] out_second_x,
  input logic signed [lfe_pkg::OUT_W-1:0] out_second_y,
  input logic                             out_cut_left_right,
  input logic                             out_degenerate,
  input logic                             out_saturated
);

  // Coincident endpoints give an all-zero result
  `ASSERT_SAME(a_degen_zero, out_valid && out_degenerate, out_first_x == 0 && out_first_y == 0 && out_second_x == 0 && out_second_y == 0 && !out_cut_left_right && !out_saturated, "degenerate result not cleared")

  // Horizontal cut starts at the left border
  `ASSERT_SAME(a_horiz_left, out_valid && out_cut_left_right, out_first_x == 0 && out_first_y == out_second_y, "horizontal cut malformed")

  // Other segments start on the top border
  `ASSERT_SAME(a_top_edge, out_valid && !out_cut_left_right && !out_degenerate, out_first_y == 0, "first point off top border")

  // A stalled result stays valid, with second_x and saturated unchanged
  `ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_second_x) && $stable(out_saturated), "stalled result changed")

endmodule

bind line_extend_to_frame_edges_unit lfe_chk u_lfe_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_first_x        (out_first_x),
  .out_first_y        (out_first_y),
  .out_second_x       (out_second_x),
  .out_second_y       (out_second_y),
  .out_cut_left_right (out_cut_left_right),
  .out_degenerate     (out_degenerate),
  .out_saturated      (out_saturated)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line extension unit. Segments are pushed through
// the input channel under several idle/stall mixes and frame sizes; each
// result is compared against a behavioral border intersection computed here.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CB = 12;
  localparam int FB = 4;
  localparam int SEG_W = 4 * CB;
  localparam int LATENCY = 13;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [lfe_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [CB-1:0] xs, ys, xe, ye;
  } segment_t;

  typedef struct packed {
    logic signed [lfe_pkg::OUT_W-1:0] fx, fy, sx, sy;
    logic horiz, degen, sat;
  } border_pts_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lfe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lfe_pkg::REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] in_x_start = '0, in_y_start = '0, in_x_end = '0, in_y_end = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [lfe_pkg::OUT_W-1:0] out_first_x, out_first_y, out_second_x, out_second_y;
  logic out_cut_left_right, out_degenerate, out_saturated;

  line_extend_to_frame_edges_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (.*);

  always #6 clk = ~clk;

  // Local copy of the frame size registers
  logic [lfe_pkg::REG_W-1:0] height_q = lfe_pkg::HEIGHT_RST;
  logic [lfe_pkg::REG_W-1:0] width_q  = lfe_pkg::WIDTH_RST;

  segment_t    pending_segs[$];
  border_pts_t expected_pts[$];
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int seg_count = 0;
  int res_count = 0;
  int quiet_cycles = 0;

  // Rounded division, ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [lfe_pkg::OUT_W-1:0] clamp24(longint v, inout logic sat);
    if (v > 64'sd8388607) begin
      sat = 1'b1;
      return 24'sh7FFFFF;
    end else if (v < -64'sd8388608) begin
      sat = 1'b1;
      return 24'sh800000;
    end
    return v[lfe_pkg::OUT_W-1:0];
  endfunction

  function automatic border_pts_t intersect_borders(segment_t s);
    border_pts_t r;
    longint x1, y1, x2, y2, dx, dy, h, w, fx, fy, sx, sy;
    logic sat;
    x1 = s.xs; y1 = s.ys; x2 = s.xe; y2 = s.ye;
    h = height_q; w = width_q;
    sat = 1'b0;
    r.horiz = 1'b0;
    r.degen = 1'b0;
    if (x1 == x2 && y1 == y2) begin
      r.degen = 1'b1;
      fx = 0; fy = 0; sx = 0; sy = 0;
    end else if (y1 == y2) begin
      r.horiz = 1'b1;
      fx = 0; fy = y1 << FB; sx = w << FB; sy = y1 << FB;
    end else begin
      dx = x2 - x1; dy = y2 - y1;
      if (dy < 0) begin
        dx = -dx; dy = -dy;
      end
      fx = round_div((x1 * dy - y1 * dx) * (1 << FB), dy);
      fy = 0;
      sx = round_div((x1 * dy + (h - y1) * dx) * (1 << FB), dy);
      sy = h << FB;
    end
    r.fx = clamp24(fx, sat);
    r.fy = clamp24(fy, sat);
    r.sx = clamp24(sx, sat);
    r.sy = clamp24(sy, sat);
    r.sat = sat;
    return r;
  endfunction

  function automatic segment_t rand_seg();
    segment_t s;
    int k;
    s = SEG_W'({$urandom, $urandom});
    k = $urandom_range(0, 9);
    if (k == 0) begin
      s.xe = s.xs; s.ye = s.ys;
    end else if (k == 1) begin
      s.ye = s.ys;
    end else if (k == 2) begin
      s.ye = s.ys + (($urandom_range(0, 1) != 0) ? 12'd1 : 12'hFFF);
    end else if (k == 3) begin
      s.xe = s.xs;
    end
    return s;
  endfunction

  // Segment driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_segs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          segment_t s;
          s = pending_segs.pop_front();
          in_valid <= 1'b1;
          {in_x_start, in_y_start, in_x_end, in_y_end} <= s;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Input transfer: predict; output transfer: check
  always @(posedge clk) begin
    if (rst_n) begin
      bit moved;
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        expected_pts.push_back(intersect_borders({in_x_start, in_y_start,
                                                  in_x_end, in_y_end}));
        seg_count <= seg_count + 1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        res_count <= res_count + 1;
        if (expected_pts.size() == 0) begin
          $error("result transfer with no expectation pending");
          errors++;
        end else begin
          border_pts_t e;
          e = expected_pts.pop_front();
          if (out_first_x !== e.fx) begin
            $error("first_x exp %0d got %0d", e.fx, out_first_x); errors++;
          end
          if (out_first_y !== e.fy) begin
            $error("first_y exp %0d got %0d", e.fy, out_first_y); errors++;
          end
          if (out_second_x !== e.sx) begin
            $error("second_x exp %0d got %0d", e.sx, out_second_x); errors++;
          end
          if (out_second_y !== e.sy) begin
            $error("second_y exp %0d got %0d", e.sy, out_second_y); errors++;
          end
          if (out_cut_left_right !== e.horiz) begin
            $error("cut_left_right exp %0b got %0b", e.horiz, out_cut_left_right);
            errors++;
          end
          if (out_degenerate !== e.degen) begin
            $error("degenerate exp %0b got %0b", e.degen, out_degenerate);
            errors++;
          end
          if (out_saturated !== e.sat) begin
            $error("saturated exp %0b got %0b", e.sat, out_saturated);
            errors++;
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired: %0d segments sent, %0d results", seg_count, res_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [lfe_pkg::CFG_IDX_W-1:0] idx,
                           logic [lfe_pkg::REG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lfe_pkg::CFG_FRAME_HEIGHT) height_q = val;
    else if (idx == lfe_pkg::CFG_FRAME_WIDTH) width_q = val;
  endtask

  // Wait until every queued segment has been sent and checked
  task automatic drain();
    do @(negedge clk);
    while (pending_segs.size() != 0 || in_valid || expected_pts.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_seg(int xs, int ys, int xe, int ye);
    segment_t s;
    s.xs = CB'(xs); s.ys = CB'(ys); s.xe = CB'(xe); s.ye = CB'(ye);
    pending_segs.push_back(s);
  endtask

  int heights[6] = '{480, 1, 4096, 8191, 0, 1080};
  int widths[6]  = '{640, 4096, 1, 8191, 0, 1920};
  int idles[6]   = '{0, 65, 0, 18, 0, 40};
  int stalls[6]  = '{0, 0, 65, 18, 0, 30};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, horizontal, vertical, coincident, saturation
    push_seg(0, 0, 0, 0);
    push_seg(4095, 4095, 4095, 4095);
    push_seg(0, 100, 4095, 100);
    push_seg(4095, 0, 0, 0);
    push_seg(10, 0, 10, 4095);
    push_seg(0, 0, 4095, 1);
    push_seg(4095, 1, 0, 0);
    push_seg(0, 4095, 4095, 4094);
    push_seg(4095, 4094, 0, 4095);
    push_seg(1, 2, 2, 5);
    push_seg(3, 7, 0, 1);
    push_seg(0, 0, 1, 3);
    push_seg(2730, 1365, 1365, 2730);
    push_seg(0, 0, 4095, 4095);
    push_seg(5, 3, 6, 4);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(lfe_pkg::CFG_FRAME_HEIGHT, lfe_pkg::REG_W'(heights[p]));
      write_reg(lfe_pkg::CFG_FRAME_WIDTH, lfe_pkg::REG_W'(widths[p]));
      if (p == 4) write_reg(CFG_IDX_UNUSED, 13'h1ABC);
      idle_pct = idles[p];
      stall_pct = stalls[p];
      repeat (190) pending_segs.push_back(rand_seg());
      drain();
    end
    stall_pct = 0;
    repeat (LATENCY + 4) @(posedge clk);

    $display("Covered %0d segments and %0d results over six frame sizes", seg_count,
             res_count);
    $display("including zero and full-range registers and mixed idle/stall phases.");
    if (errors == 0 && expected_pts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lfe_pkg.sv
hw/rtl/lfe_div.sv
hw/rtl/line_extend_to_frame_edges_unit.sv
hw/rtl/lfe_chk.sv
tb/tb_top.sv
